// ===== src/nnd_pkg.sv =====
// Shared types and constants for the NetBIOS name-service name decoder.
// No dependencies; every other file of the block imports this package.
package nnd_pkg;

  // Byte positions of interest within the payload.
  localparam logic [15:0] POS_OPCODE = 16'd2;
  localparam logic [15:0] POS_LENGTH = 16'd12;
  localparam logic [15:0] POS_MAX    = 16'hFFFF;

  // Header length, and header plus length byte plus one trailing byte.
  localparam logic [16:0] HDR_LEN      = 17'd12;
  localparam logic [16:0] MIN_OVERHEAD = 17'd14;

  // First-level encoding uses the characters 'A' to 'P'.
  localparam logic [7:0] CHAR_FIRST = 8'h41;
  localparam logic [7:0] CHAR_LAST  = 8'h50;

  // Registration opcode, the value of the register after reset.
  localparam logic [3:0] OPCODE_RESET = 4'd5;

  // Result queue depth: one waiting result plus the two one beat can produce.
  localparam int unsigned QUEUE_DEPTH = 3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_SHORT     = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_INVALID   = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic {
    KIND_NAME   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_byte;
    status_t     status;
    logic        malformed;
    logic        last;
  } result_t;

  // Results of one input beat: a name byte first, then the frame status.
  typedef struct packed {
    logic    name_vld;
    result_t name_res;
    logic    stat_vld;
    result_t stat_res;
  } step_out_t;

endpackage

// ===== src/nnd_decode.sv =====
// Per-byte frame state and first-level name decoding.
// Depends on nnd_pkg; feeds its results to the result queue.
module nnd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              frame_end,
  input  logic [3:0]        accepted_opcode,
  output nnd_pkg::step_out_t res
);
  import nnd_pkg::*;

  logic [15:0] byte_position_r, byte_position_nxt;
  logic [3:0]  opcode_seen_r, opcode_seen_nxt;
  logic [7:0]  declared_length_r, declared_length_nxt;
  logic [7:0]  chars_left_r, chars_left_nxt;
  logic        half_pending_r, half_pending_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic        decode_stopped_r, decode_stopped_nxt;

  logic [15:0] total;
  logic [7:0]  char_off;
  logic        in_range;
  logic        match_now;
  logic        match_end;
  status_t     st;

  assign char_off = data_byte - CHAR_FIRST;
  assign in_range = (data_byte >= CHAR_FIRST) && (data_byte <= CHAR_LAST);
  assign match_now = opcode_seen_r == accepted_opcode;
  assign total = (byte_position_r == POS_MAX) ? POS_MAX : byte_position_r + 16'd1;

  always_comb begin
    opcode_seen_nxt     = opcode_seen_r;
    declared_length_nxt = declared_length_r;
    chars_left_nxt      = chars_left_r;
    half_pending_nxt    = half_pending_r;
    high_nibble_nxt     = high_nibble_r;
    decode_stopped_nxt  = decode_stopped_r;
    byte_position_nxt   = total;
    res                 = '0;
    res.name_res.kind   = KIND_NAME;
    res.stat_res.kind   = KIND_STATUS;
    res.stat_res.last   = 1'b1;
    st                  = ST_OK;
    match_end           = 1'b0;

    if (byte_position_r == POS_OPCODE) begin
      opcode_seen_nxt = data_byte[6:3];
    end else if (byte_position_r == POS_LENGTH) begin
      declared_length_nxt = data_byte;
      chars_left_nxt      = data_byte;
      half_pending_nxt    = 1'b0;
      high_nibble_nxt     = 4'd0;
      decode_stopped_nxt  = 1'b0;
    end else if (byte_position_r > POS_LENGTH && match_now && !decode_stopped_r &&
                 chars_left_r != 8'd0) begin
      if (in_range) begin
        if (half_pending_r) begin
          res.name_vld           = 1'b1;
          res.name_res.name_byte = {high_nibble_r, char_off[3:0]};
          half_pending_nxt       = 1'b0;
        end else begin
          high_nibble_nxt  = char_off[3:0];
          half_pending_nxt = 1'b1;
        end
        chars_left_nxt = chars_left_r - 8'd1;
      end else begin
        decode_stopped_nxt = 1'b1;
      end
    end

    if (frame_end) begin
      // The opcode test uses the value as it stands after this byte.
      match_end = opcode_seen_nxt == accepted_opcode;
      if ({1'b0, total} < HDR_LEN) begin
        st = ST_SHORT;
      end else if (!match_end) begin
        st = ST_IGNORED;
      end else if ({1'b0, total} == HDR_LEN) begin
        st = ST_TRUNCATED;
      end else if ({1'b0, total} < {9'd0, declared_length_nxt} + MIN_OVERHEAD) begin
        st = ST_TOO_LONG;
      end else if (chars_left_nxt != 8'd0 || half_pending_nxt) begin
        st = ST_INVALID;
      end else if (declared_length_nxt == 8'd0) begin
        st = ST_EMPTY;
      end else begin
        st = ST_OK;
      end
      res.stat_vld           = 1'b1;
      res.stat_res.status    = st;
      res.stat_res.malformed = st == ST_SHORT;

      byte_position_nxt   = 16'd0;
      opcode_seen_nxt     = 4'd0;
      declared_length_nxt = 8'd0;
      chars_left_nxt      = 8'd0;
      half_pending_nxt    = 1'b0;
      high_nibble_nxt     = 4'd0;
      decode_stopped_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r   <= 16'd0;
      opcode_seen_r     <= 4'd0;
      declared_length_r <= 8'd0;
      chars_left_r      <= 8'd0;
      half_pending_r    <= 1'b0;
      high_nibble_r     <= 4'd0;
      decode_stopped_r  <= 1'b0;
    end else if (accept) begin
      byte_position_r   <= byte_position_nxt;
      opcode_seen_r     <= opcode_seen_nxt;
      declared_length_r <= declared_length_nxt;
      chars_left_r      <= chars_left_nxt;
      half_pending_r    <= half_pending_nxt;
      high_nibble_r     <= high_nibble_nxt;
      decode_stopped_r  <= decode_stopped_nxt;
    end
  end

  // Every frame end leaves the counter at the start of a new frame.
  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_end) |=> (byte_position_r == 16'd0 && !half_pending_r))
    else $error("frame state not cleared after frame end");

  // A name byte only ever completes a pair that was pending.
  a_pair_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.name_vld) |-> half_pending_r)
    else $error("name byte emitted without a pending half");

endmodule

// ===== src/nnd_outq.sv =====
// Three-entry result queue; takes up to two results a beat, gives one.
// Depends on nnd_pkg; its head drives the result ports of the top level.
module nnd_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nnd_pkg::step_out_t res,
  input  logic               out_ready,
  output logic               out_valid,
  output nnd_pkg::result_t   head,
  output logic               in_ready
);
  import nnd_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t           q_r   [QUEUE_DEPTH];
  result_t           q_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  base;
  logic [CNT_W-1:0]  n_push;
  logic              pop;
  result_t           first;
  result_t           keep;

  assign out_valid = count_r != '0;
  assign head      = q_r[0];
  assign pop       = out_valid && out_ready;
  assign base      = count_r - CNT_W'(pop);
  // Room for the worst case of two results from the next beat.
  assign in_ready  = base <= CNT_W'(QUEUE_DEPTH - 2);
  assign n_push    = push ? CNT_W'(res.name_vld) + CNT_W'(res.stat_vld) : '0;
  assign first     = res.name_vld ? res.name_res : res.stat_res;
  assign count_nxt = base + n_push;

  always_comb begin
    keep = q_r[0];
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep = q_r[i];
      if (pop && (i + 1 < QUEUE_DEPTH)) begin
        keep = q_r[(i + 1) % QUEUE_DEPTH];
      end
      if (CNT_W'(i) < base) begin
        q_nxt[i] = keep;
      end else if (CNT_W'(i) == base && n_push != '0) begin
        q_nxt[i] = first;
      end else if ((CNT_W + 1)'(i) == {1'b0, base} + (CNT_W + 1)'(1) &&
                   n_push == CNT_W'(2)) begin
        q_nxt[i] = res.stat_res;
      end else begin
        q_nxt[i] = keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ({1'b0, base} + {1'b0, n_push}) <= (CNT_W + 1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (push && n_push == CNT_W'(2)) |=> count_r >= CNT_W'(2))
    else $error("second result of a beat lost");

endmodule

// ===== src/netbios_ns_name_decoder.sv =====
// Top level of the NetBIOS name-service first-level name decoder.
// Depends on nnd_pkg, nnd_decode and nnd_outq.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_data_byte, in_frame_end
//   out_     output     out_valid / out_ready out_kind, out_name_byte, out_status,
//                                             out_malformed, out_last
//   cfg_     input      cfg_we                cfg_accepted_opcode
//
// One byte is accepted per cycle while in_ready is high; the frame state is
// updated at acceptance and its results are registered in a three-entry queue
// ahead of the out_ ports. A beat can yield two results (name byte then
// status), which leave the queue one at a time. in_ready falls only when the
// queue could not take two more results. Synchronous active-low reset empties
// the queue, clears the frame state and sets the opcode register to registration.
module netbios_ns_name_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_name_byte,
  output logic [2:0]  out_status,
  output logic        out_malformed,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_accepted_opcode
);
  import nnd_pkg::*;

  logic [3:0] accepted_opcode_r;
  logic       accept;
  step_out_t  step_res;
  result_t    head;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_opcode_r <= OPCODE_RESET;
    end else if (cfg_we) begin
      accepted_opcode_r <= cfg_accepted_opcode;
    end
  end

  nnd_decode u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .frame_end       (in_frame_end),
    .accepted_opcode (accepted_opcode_r),
    .res             (step_res)
  );

  nnd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .res       (step_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .in_ready  (in_ready)
  );

  assign out_kind      = head.kind;
  assign out_name_byte = head.name_byte;
  assign out_status    = head.status;
  assign out_malformed = head.malformed;
  assign out_last      = head.last;

  // The malformed flag goes with the short-header status and nothing else.
  a_malformed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_malformed == (out_kind && out_status == ST_SHORT)))
    else $error("malformed flag disagrees with status");

endmodule

// ===== sim/netbios_ns_name_decoder_test.sv =====
// Self-checking testbench for the NetBIOS name-service first-level name decoder.
// Depends on nnd_pkg and netbios_ns_name_decoder; a built-in predictor checks every result beat.
`timescale 1ns / 1ps

module netbios_ns_name_decoder_test;
  import nnd_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kind;
  logic [7:0] out_name_byte;
  logic [2:0] out_status;
  logic       out_malformed;
  logic       out_last;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_accepted_opcode = OPCODE_RESET;

  netbios_ns_name_decoder u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_frame_end        (in_frame_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_name_byte       (out_name_byte),
    .out_status          (out_status),
    .out_malformed       (out_malformed),
    .out_last            (out_last),
    .cfg_we              (cfg_we),
    .cfg_accepted_opcode (cfg_accepted_opcode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted decoder state, mirroring the block's frame registers.
  logic [3:0]  want_opcode = OPCODE_RESET;
  logic [15:0] frame_pos = '0;
  logic [3:0]  frame_opcode = '0;
  logic [7:0]  name_len = '0;
  logic [7:0]  chars_todo = '0;
  logic        pair_open = 1'b0;
  logic [3:0]  upper_nibble = '0;
  logic        name_halted = 1'b0;

  result_t    decoded_results[$];
  logic [7:0] frame_buf[$];
  int         errors = 0;
  int         beats_sent = 0;
  bit         tx_idle = 1'b1;
  bit         rx_idle = 1'b1;
  int         rx_hold = 0;

  task automatic clear_frame_state();
    frame_pos    = '0;
    frame_opcode = '0;
    name_len     = '0;
    chars_todo   = '0;
    pair_open    = 1'b0;
    upper_nibble = '0;
    name_halted  = 1'b0;
  endtask

  // Works out the result beats caused by one accepted payload byte.
  task automatic decode_beat(input logic [7:0] b, input logic fe);
    result_t     r;
    logic [16:0] total;
    logic [7:0]  offset;
    logic        match;
    match = (frame_opcode == want_opcode);
    if (frame_pos == POS_OPCODE) begin
      frame_opcode = b[6:3];
    end else if (frame_pos == POS_LENGTH) begin
      name_len     = b;
      chars_todo   = b;
      pair_open    = 1'b0;
      upper_nibble = '0;
      name_halted  = 1'b0;
    end else if (frame_pos > POS_LENGTH && match && !name_halted && chars_todo != 0) begin
      if (b >= CHAR_FIRST && b <= CHAR_LAST) begin
        offset = b - CHAR_FIRST;
        if (pair_open) begin
          r           = '0;
          r.kind      = KIND_NAME;
          r.name_byte = {upper_nibble, offset[3:0]};
          r.status    = ST_OK;
          decoded_results.push_back(r);
          pair_open = 1'b0;
        end else begin
          upper_nibble = offset[3:0];
          pair_open    = 1'b1;
        end
        chars_todo = chars_todo - 8'd1;
      end else begin
        name_halted = 1'b1;
      end
    end
    total = {1'b0, frame_pos} + 17'd1;
    if (total > {1'b0, POS_MAX}) total = {1'b0, POS_MAX};
    frame_pos = total[15:0];
    if (fe) begin
      r      = '0;
      r.kind = KIND_STATUS;
      r.last = 1'b1;
      if (total < HDR_LEN) begin
        r.status    = ST_SHORT;
        r.malformed = 1'b1;
      end else if (frame_opcode != want_opcode) begin
        r.status = ST_IGNORED;
      end else if (total == HDR_LEN) begin
        r.status = ST_TRUNCATED;
      end else if (total < {9'd0, name_len} + MIN_OVERHEAD) begin
        r.status = ST_TOO_LONG;
      end else if (chars_todo != 0 || pair_open) begin
        r.status = ST_INVALID;
      end else if (name_len == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_OK;
      end
      decoded_results.push_back(r);
      clear_frame_state();
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual kind %0d byte %0h status %0d",
                 $time, out_kind, out_name_byte, out_status);
        errors++;
      end else begin
        want = decoded_results.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("name_byte", want.name_byte, out_name_byte);
        check_field("status", want.status, out_status);
        check_field("malformed", want.malformed, out_malformed);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Receiver back-pressure: random stalls while rx_idle is set.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_hold   <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic fe);
    int gap;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_frame_end <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_beat(b, fe);
    beats_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_beat(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Holds the sender off until every predicted result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_opcode(input logic [3:0] op);
    drain_results();
    cfg_we              <= 1'b1;
    cfg_accepted_opcode <= op;
    @(posedge clk);
    cfg_we      <= 1'b0;
    want_opcode = op;
  endtask

  task automatic start_header(input logic [3:0] op);
    logic [7:0] flags_hi;
    frame_buf.delete();
    repeat (12) frame_buf.push_back(8'($urandom_range(0, 255)));
    flags_hi     = frame_buf[2];
    frame_buf[2] = {flags_hi[7], op, flags_hi[2:0]};
  endtask

  task automatic add_random(input int n);
    repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_name(input int len);
    frame_buf.push_back(8'(len));
    repeat (len) frame_buf.push_back(CHAR_FIRST + 8'($urandom_range(0, 15)));
  endtask

  task automatic test_good_names();
    start_header(OPCODE_RESET);
    frame_buf.push_back(8'd4);
    frame_buf.push_back(CHAR_FIRST);
    frame_buf.push_back(CHAR_FIRST);
    frame_buf.push_back(CHAR_LAST);
    frame_buf.push_back(CHAR_LAST);
    add_random(1);
    send_frame();
    start_header(OPCODE_RESET);
    add_name(6);
    add_random(2);
    send_frame();
  endtask

  task automatic test_byte_extremes();
    // An all-zero header but for the opcode byte, and an all-ones one carrying opcode fifteen.
    frame_buf.delete();
    repeat (12) frame_buf.push_back(8'h00);
    frame_buf[2] = {1'b0, OPCODE_RESET, 3'b000};
    frame_buf.push_back(8'd0);
    frame_buf.push_back(8'h00);
    send_frame();
    frame_buf.delete();
    repeat (14) frame_buf.push_back(8'hFF);
    send_frame();
  endtask

  task automatic test_short_header();
    frame_buf.delete();
    add_random(1);
    send_frame();
    frame_buf.delete();
    add_random(3);
    send_frame();
    frame_buf.delete();
    add_random(11);
    send_frame();
  endtask

  task automatic test_other_opcode();
    start_header(OPCODE_RESET ^ 4'd1);
    add_name(4);
    add_random(1);
    send_frame();
  endtask

  task automatic test_truncated();
    start_header(OPCODE_RESET);
    send_frame();
  endtask

  task automatic test_too_long();
    // The final character completes a pair on the frame-end byte itself.
    start_header(OPCODE_RESET);
    add_name(6);
    send_frame();
    start_header(OPCODE_RESET);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(CHAR_LAST);
    frame_buf.push_back(CHAR_FIRST);
    send_frame();
  endtask

  task automatic test_invalid();
    start_header(OPCODE_RESET);
    frame_buf.push_back(8'd4);
    frame_buf.push_back(CHAR_FIRST);
    frame_buf.push_back(CHAR_LAST + 8'd1);
    frame_buf.push_back(CHAR_FIRST);
    frame_buf.push_back(CHAR_FIRST);
    add_random(1);
    send_frame();
    start_header(OPCODE_RESET);
    frame_buf.push_back(8'd2);
    frame_buf.push_back(CHAR_FIRST - 8'd1);
    frame_buf.push_back(CHAR_FIRST);
    add_random(1);
    send_frame();
    // An odd character count leaves half a pair.
    start_header(OPCODE_RESET);
    add_name(3);
    add_random(1);
    send_frame();
  endtask

  task automatic test_empty();
    start_header(OPCODE_RESET);
    add_name(0);
    add_random(1);
    send_frame();
  endtask

  task automatic test_opcode_register();
    write_opcode(4'd0);
    start_header(4'd0);
    add_name(2);
    add_random(1);
    send_frame();
    write_opcode(4'd15);
    start_header(4'd15);
    add_name(2);
    add_random(1);
    send_frame();
    start_header(OPCODE_RESET);
    add_name(2);
    add_random(1);
    send_frame();
    write_opcode(OPCODE_RESET);
  endtask

  task automatic random_frame();
    int kind;
    int len;
    int pos;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      start_header(want_opcode);
      if ($urandom_range(0, 29) == 0) len = $urandom_range(0, 255);
      else if ($urandom_range(0, 9) == 0) len = 2 * $urandom_range(0, 10) + 1;
      else len = 2 * $urandom_range(0, 12);
      add_name(len);
      add_random($urandom_range(1, 3));
      if (len > 0 && $urandom_range(0, 7) == 0) begin
        pos = 13 + $urandom_range(0, len - 1);
        frame_buf[pos] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) if (frame_buf.size() > 1) void'(frame_buf.pop_back());
      end
    end else if (kind == 6) begin
      start_header(want_opcode ^ 4'($urandom_range(1, 15)));
      add_name(2 * $urandom_range(0, 6));
      add_random($urandom_range(1, 3));
    end else if (kind == 7) begin
      frame_buf.delete();
      add_random($urandom_range(1, 11));
    end else if (kind == 8) begin
      start_header(want_opcode);
      if ($urandom_range(0, 1) == 1) begin
        len = $urandom_range(1, 20);
        frame_buf.push_back(8'(len));
        repeat ($urandom_range(0, len)) frame_buf.push_back(CHAR_FIRST + 8'($urandom_range(0, 15)));
      end
    end else begin
      frame_buf.delete();
      add_random($urandom_range(1, 40));
    end
    send_frame();
  endtask

  task automatic test_random_traffic(input int beats);
    int stop_at;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) random_frame();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_names();
    test_byte_extremes();
    test_short_header();
    test_other_opcode();
    test_truncated();
    test_too_long();
    test_invalid();
    test_empty();
    drain_results();
    test_opcode_register();
    test_random_traffic(300);
    write_opcode(4'd0);
    test_random_traffic(300);
    write_opcode(4'd15);
    test_random_traffic(300);
    write_opcode(4'($urandom_range(0, 15)));
    // The closing stretch runs with neither side idling.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_traffic(300);
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[netbios_ns_name_decoder] OK");
    end else begin
      $display("[netbios_ns_name_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[netbios_ns_name_decoder] ERROR");
    $finish;
  end

endmodule
